FILE: rtl/pulse_width_frame_encoder_assert.svh
// Assertion macros for the pulse-width frame encoder.
// Included by the top level; no other dependencies.
`ifndef PULSE_WIDTH_FRAME_ENCODER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PWFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfe assertion failed");
`define PWFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwfe assertion failed");
`else
`define PWFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PWFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pwfe_pkg.sv
// Shared types, constants and helpers for the pulse-width frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package pwfe_pkg;

    localparam int MAX_BITS    = 63;
    localparam int FIFO_DEPTH  = 2;

    localparam int BitCountW   = 6;
    localparam int ShortCodeW  = 4;
    localparam int MultCodeW   = 3;
    localparam int PayloadW    = 64;
    localparam int MinBitsW    = 6;
    localparam int CapacityW   = 10;
    localparam int CfgDataW    = 10;
    localparam int CfgIndexW   = 1;
    localparam int ShortW      = 10;
    localparam int HighW       = 13;
    localparam int LowW        = 15;
    localparam int IdxW        = $clog2(PayloadW);

    localparam logic [MinBitsW-1:0]  MIN_BITS_RESET = MinBitsW'(16);
    localparam logic [CapacityW-1:0] CAPACITY_RESET = CapacityW'(128);

    typedef enum logic [CfgIndexW-1:0] {
        REG_MIN_BITS = 1'b0,
        REG_CAPACITY = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BitCountW-1:0]  bit_count;
        logic [ShortCodeW-1:0] short_code;
        logic [MultCodeW-1:0]  mult_code;
        logic [PayloadW-1:0]   payload;
    } in_t;

    typedef struct packed {
        logic            accepted;
        logic [HighW-1:0] high_len;
        logic [LowW-1:0]  low_len;
        logic            is_sync;
        logic            last;
    } out_t;

    typedef struct packed {
        logic                 accepted;
        logic [BitCountW-1:0] bit_count;
        logic [ShortW-1:0]    short_len;
        logic [HighW-1:0]     long_len;
        logic [LowW-1:0]      sync_low;
        logic [PayloadW-1:0]  payload;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REJECT,
        BK_BITS,
        BK_SYNC
    } back_state_t;

    function automatic logic [ShortW-1:0] short_of(input logic [ShortCodeW-1:0] code);
        logic [ShortW-1:0] base;
        base = ShortW'(150);
        return base + ShortW'(code) * ShortW'(50);
    endfunction

endpackage

FILE: rtl/pwfe_front.sv
// Front end: input register, configuration registers, request check and
// duration setup. Depends on pwfe_pkg.
`timescale 1ns / 1ps

module pwfe_front #(
    parameter int MaxBits = pwfe_pkg::MAX_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pwfe_pkg::in_t                      in_data,
    input  logic                               cfg_we,
    input  logic [pwfe_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [pwfe_pkg::CfgDataW-1:0]      cfg_data,
    output logic                               push,
    output pwfe_pkg::cmd_t                     push_data,
    input  logic                               fifo_full
);
    import pwfe_pkg::*;

    logic                  stage_valid_reg;
    in_t                   stage_reg;
    logic [MinBitsW-1:0]   min_bits_reg;
    logic [CapacityW-1:0]  capacity_reg;
    logic [ShortW-1:0]     short_len;
    logic [HighW-1:0]      long_len;
    logic [CapacityW:0]    slices;
    logic                  reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bits_reg <= MIN_BITS_RESET;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_BITS: min_bits_reg <= cfg_data[MinBitsW-1:0];
                REG_CAPACITY: capacity_reg <= cfg_data[CapacityW-1:0];
                default:      min_bits_reg <= min_bits_reg;
            endcase
        end
    end

    assign in_stall = stage_valid_reg && fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            stage_reg <= in_data;
        end
    end

    // classify and set up durations
    always_comb
    begin
        short_len = short_of(stage_reg.short_code);
        long_len  = HighW'(short_len) * (HighW'(stage_reg.mult_code) + HighW'(2));
        slices    = {(CapacityW + 1 - BitCountW)'(0), stage_reg.bit_count} * (CapacityW + 1)'(2)
                    + (CapacityW + 1)'(2);
        reject    = (stage_reg.bit_count < min_bits_reg)
                    || (stage_reg.bit_count > BitCountW'(MaxBits))
                    || (slices > {1'b0, capacity_reg});

        push_data.accepted  = !reject;
        push_data.bit_count = stage_reg.bit_count;
        push_data.short_len = short_len;
        push_data.long_len  = long_len;
        push_data.sync_low  = (LowW'(short_len) << 5) - LowW'(short_len);
        push_data.payload   = stage_reg.payload;
    end

    assign push = stage_valid_reg && !fifo_full;

endmodule

FILE: rtl/pwfe_fifo.sv
// Short command queue between front and back end.
// Depends on pwfe_pkg.
`timescale 1ns / 1ps

module pwfe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwfe_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output pwfe_pkg::cmd_t pop_data,
    output logic           empty
);
    import pwfe_pkg::*;

    localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CntW = $clog2(FIFO_DEPTH + 1);

    cmd_t            entry_reg [FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = (count_reg == CntW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pwfe_back.sv
// Back end: steps through one command, one pulse pair per cycle while the output
// is not stalled, into the output register. Depends on pwfe_pkg.
`timescale 1ns / 1ps

module pwfe_back #(
    parameter int MaxBits = pwfe_pkg::MAX_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fifo_empty,
    input  pwfe_pkg::cmd_t fifo_data,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output pwfe_pkg::out_t pulse_pair
);
    import pwfe_pkg::*;

    localparam int CntW = $clog2(MaxBits + 1);

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CntW-1:0]  bits_left_reg, bits_left_next;
    logic             out_valid_reg, out_valid_next;
    out_t             pulse_pair_reg, pulse_pair_next;
    logic             out_free;
    logic             cur_bit;

    assign out_free   = !out_valid_reg || !out_stall;
    assign cur_bit    = cmd_reg.payload[IdxW'(bits_left_reg - 1'b1)];
    assign out_valid  = out_valid_reg;
    assign pulse_pair = pulse_pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            bits_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pulse_pair_reg <= pulse_pair_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        bits_left_next  = bits_left_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pulse_pair_next = pulse_pair_reg;
        pop             = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop            = 1'b1;
                    cmd_next       = fifo_data;
                    bits_left_next = CntW'(fifo_data.bit_count);
                    if (!fifo_data.accepted)
                    begin
                        state_next = BK_REJECT;
                    end
                    else if (fifo_data.bit_count == '0)
                    begin
                        state_next = BK_SYNC;
                    end
                    else
                    begin
                        state_next = BK_BITS;
                    end
                end
            end
            BK_REJECT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    pulse_pair_next.accepted = 1'b0;
                    pulse_pair_next.high_len = '0;
                    pulse_pair_next.low_len  = '0;
                    pulse_pair_next.is_sync  = 1'b0;
                    pulse_pair_next.last     = 1'b1;
                    state_next               = BK_IDLE;
                end
            end
            BK_BITS:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    pulse_pair_next.accepted = 1'b1;
                    pulse_pair_next.is_sync  = 1'b0;
                    pulse_pair_next.last     = 1'b0;
                    if (cur_bit)
                    begin
                        pulse_pair_next.high_len = cmd_reg.long_len;
                        pulse_pair_next.low_len  = LowW'(cmd_reg.short_len);
                    end
                    else
                    begin
                        pulse_pair_next.high_len = HighW'(cmd_reg.short_len);
                        pulse_pair_next.low_len  = LowW'(cmd_reg.long_len);
                    end
                    bits_left_next = bits_left_reg - 1'b1;
                    if (bits_left_reg == CntW'(1))
                    begin
                        state_next = BK_SYNC;
                    end
                end
            end
            BK_SYNC:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    pulse_pair_next.accepted = 1'b1;
                    pulse_pair_next.high_len = HighW'(cmd_reg.short_len);
                    pulse_pair_next.low_len  = cmd_reg.sync_low;
                    pulse_pair_next.is_sync  = 1'b1;
                    pulse_pair_next.last     = 1'b1;
                    state_next               = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pulse_width_frame_encoder.sv
// Top level of the pulse-width frame encoder: front end, command queue, back end.
// Depends on pwfe_pkg, pwfe_front, pwfe_fifo, pwfe_back and the assertion header.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one frame request per
//   transaction. Output channel (out_valid / out_stall / pulse_pair) gives the
//   pulse pairs: one per payload bit, most significant first, then the sync
//   pair flagged last. A rejected request gives one result with accepted low.
//   Configuration (cfg_we / cfg_index / cfg_data) writes min_bits and
//   capacity_slices; write only while the block is idle.
// Path: after the accepting edge a request goes through the queue write, the
//   back-end load and the output register.
// Sequence: the back end loads a request, gives its n bit pairs, then one sync
//   pair; a rejected one is loaded and gives its one result. It loads the next
//   command only from idle; the front end and a two-entry queue run ahead.
// Reset: clears all control state and restores min_bits to 16 and
//   capacity_slices to 128.
// Stall: a stalled output holds its result; the back end waits, the queue
//   fills, and then in_stall rises.
`timescale 1ns / 1ps
`include "pulse_width_frame_encoder_assert.svh"

module pulse_width_frame_encoder #(
    parameter int MaxBits = pwfe_pkg::MAX_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pwfe_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pwfe_pkg::out_t                 pulse_pair,
    input  logic                           cfg_we,
    input  logic [pwfe_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [pwfe_pkg::CfgDataW-1:0]  cfg_data
);
    import pwfe_pkg::*;

    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;
    cmd_t push_data;
    cmd_t pop_data;

    pwfe_front #(
        .MaxBits(MaxBits)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .push_data(push_data),
        .fifo_full(fifo_full)
    );

    pwfe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (fifo_full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (fifo_empty)
    );

    pwfe_back #(
        .MaxBits(MaxBits)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_empty(fifo_empty),
        .fifo_data (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pulse_pair(pulse_pair)
    );

    `PWFE_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !fifo_full)
    `PWFE_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !fifo_empty)
    `PWFE_ASSERT_IMPLY(a_reject_single, clk, rst_n, out_valid && !pulse_pair.accepted,
        pulse_pair.last && !pulse_pair.is_sync && pulse_pair.high_len == '0)
    `PWFE_ASSERT_IMPLY(a_sync_is_last, clk, rst_n, out_valid && pulse_pair.accepted,
        pulse_pair.is_sync == pulse_pair.last)

endmodule

FILE: dv/pulse_width_frame_encoder_tb.sv
// Self-checking bench for pulse_width_frame_encoder: queued frame requests, random idling,
// an internal pulse-train predictor and a field-by-field scoreboard on the output channel.
// Depends on pwfe_pkg and the pulse_width_frame_encoder RTL.
`timescale 1ns / 1ps

module pulse_width_frame_encoder_tb;
    import pwfe_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 25;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b1;
    out_t                 pulse_pair;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = REG_MIN_BITS;
    logic [CfgDataW-1:0]  cfg_data = '0;

    logic [MinBitsW-1:0]  min_bits_cfg = MIN_BITS_RESET;
    logic [CapacityW-1:0] capacity_cfg = CAPACITY_RESET;

    in_t  frame_requests[$];
    out_t pending_pulses[$];
    out_t want;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int gap_max = 5;
    int stall_max = 5;
    int send_gap = 0;
    int take_gap = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    pulse_width_frame_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pulse_pair(pulse_pair),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void expand_frame(in_t req);
        int   n;
        int   short_ticks;
        int   long_ticks;
        out_t pair;
        n = req.bit_count;
        pair = '0;
        if (n < int'(min_bits_cfg) || n > MAX_BITS || 2 * n + 2 > int'(capacity_cfg))
        begin
            pair.last = 1'b1;
            pending_pulses.push_back(pair);
            return;
        end
        short_ticks = 150 + 50 * int'(req.short_code);
        long_ticks  = short_ticks * (2 + int'(req.mult_code));
        pair.accepted = 1'b1;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (req.payload[i])
            begin
                pair.high_len = HighW'(long_ticks);
                pair.low_len  = LowW'(short_ticks);
            end
            else
            begin
                pair.high_len = HighW'(short_ticks);
                pair.low_len  = LowW'(long_ticks);
            end
            pending_pulses.push_back(pair);
        end
        pair.high_len = HighW'(short_ticks);
        pair.low_len  = LowW'(short_ticks * 31);
        pair.is_sync  = 1'b1;
        pair.last     = 1'b1;
        pending_pulses.push_back(pair);
    endfunction

    function automatic void queue_request(int unsigned nbits, int unsigned scode,
                                          int unsigned mcode, logic [PayloadW-1:0] bits);
        in_t req;
        req.bit_count  = BitCountW'(nbits);
        req.short_code = ShortCodeW'(scode);
        req.mult_code  = MultCodeW'(mcode);
        req.payload    = bits;
        frame_requests.push_back(req);
    endfunction

    function automatic in_t random_request();
        in_t req;
        int  top;
        top = (capacity_cfg < 2) ? -1 : (int'(capacity_cfg) - 2) / 2;
        if (top > MAX_BITS)
            top = MAX_BITS;
        req.short_code = ShortCodeW'($urandom_range(0, 15));
        req.mult_code  = MultCodeW'($urandom_range(0, 7));
        req.payload    = {$urandom, $urandom};
        if (top >= int'(min_bits_cfg) && $urandom_range(0, 3) != 0)
            req.bit_count = BitCountW'($urandom_range(int'(min_bits_cfg), top));
        else
            req.bit_count = BitCountW'($urandom_range(0, 63));
        return req;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_BITS)
            min_bits_cfg = MinBitsW'(value);
        else
            capacity_cfg = CapacityW'(value);
        @(posedge clk);
    endtask

    task automatic set_config(int unsigned min_bits, int unsigned capacity);
        write_reg(REG_MIN_BITS, min_bits);
        write_reg(REG_CAPACITY, capacity);
    endtask

    task automatic wait_idle();
        while (frame_requests.size() != 0 || in_valid || pending_pulses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: hold a stalled transaction, then wait the drawn gap before the next one
    always @(negedge clk)
    begin
        if (in_fire)
            send_gap = $urandom_range(0, gap_max);
        if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (frame_requests.size() != 0)
            begin
                in_data  <= frame_requests.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall per transaction, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (out_fire)
            take_gap = $urandom_range(0, stall_max);
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (take_gap > 0)
        begin
            take_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (in_fire)
            expand_frame(in_data);
        if (out_fire)
        begin
            if (pending_pulses.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, pulse_pair);
            end
            else
            begin
                want = pending_pulses.pop_front();
                compare_field("accepted", 32'(want.accepted), 32'(pulse_pair.accepted));
                compare_field("high_len", 32'(want.high_len), 32'(pulse_pair.high_len));
                compare_field("low_len", 32'(want.low_len), 32'(pulse_pair.low_len));
                compare_field("is_sync", 32'(want.is_sync), 32'(pulse_pair.is_sync));
                compare_field("last", 32'(want.last), 32'(pulse_pair.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("pulse_width_frame_encoder: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_request(0, 0, 0, 64'h0);
        queue_request(15, 15, 7, '1);
        queue_request(16, 0, 0, 64'h0);
        queue_request(16, 15, 7, '1);
        queue_request(63, 0, 7, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(63, 15, 0, 64'h5555_5555_5555_5555);
        queue_request(20, 7, 3, 64'hFFFF_FFFF_FFF0_0F0F);
        queue_request(32, 3, 5, 64'h8000_0000_0000_0001);
        wait_idle();

        set_config(0, 1023);
        queue_request(0, 15, 7, '1);
        queue_request(1, 0, 0, 64'h1);
        queue_request(1, 8, 2, 64'hFFFF_FFFF_FFFF_FFFE);
        wait_idle();

        set_config(0, 2);
        queue_request(0, 5, 1, 64'h0);
        queue_request(1, 5, 1, 64'h1);
        wait_idle();

        set_config(0, 127);
        queue_request(62, 12, 6, 64'h3C3C_3C3C_3C3C_3C3C);
        queue_request(63, 12, 6, 64'h3C3C_3C3C_3C3C_3C3C);
        wait_idle();

        set_config(63, 1023);
        queue_request(62, 1, 4, '1);
        queue_request(63, 14, 3, 64'h0123_4567_89AB_CDEF);
        wait_idle();

        set_config(0, 0);
        queue_request(0, 2, 2, 64'h0);
        queue_request(63, 2, 2, '1);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            unique case (phase)
                0:
                begin
                    gap_max = 0;
                    stall_max = 0;
                    set_config(0, 1023);
                end
                1:
                begin
                    gap_max = 5;
                    stall_max = 5;
                    set_config(4, 60);
                end
                2:
                begin
                    gap_max = 0;
                    stall_max = 5;
                    set_config(8, 1023);
                    hold_seq++;
                end
                3:
                begin
                    gap_max = 5;
                    stall_max = 5;
                    set_config(63, 1023);
                end
                4:
                begin
                    gap_max = 5;
                    stall_max = 0;
                    set_config($urandom_range(0, 24), $urandom_range(0, 1023));
                end
                default:
                begin
                    gap_max = 0;
                    stall_max = 5;
                    set_config($urandom_range(0, 24), $urandom_range(2, 140));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                frame_requests.push_back(random_request());
            wait_idle();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("pulse_width_frame_encoder: match");
        else
            $display("pulse_width_frame_encoder: mismatch");
        $finish;
    end

endmodule
